// File: rtl/core/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants for the bounding-box affine transform unit.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int FRAC_W     = 16;
    localparam int TERM_W     = PROD_W - FRAC_W;
    localparam int SUM_W      = TERM_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_M00_M01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M02_TX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M10_M11 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M12_TY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_M20_M21 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_M22_TZ  = 3'd5;

    // Reset values give the identity transform
    localparam logic [CFG_DATA_W-1:0] RST_M00_M01 = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_M02_TX  = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_M10_M11 = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] RST_M12_TY  = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_M20_M21 = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_M22_TZ  = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic                      has_box;
        logic signed [COORD_W-1:0] in_min_x;
        logic signed [COORD_W-1:0] in_min_y;
        logic signed [COORD_W-1:0] in_min_z;
        logic signed [COORD_W-1:0] in_max_x;
        logic signed [COORD_W-1:0] in_max_y;
        logic signed [COORD_W-1:0] in_max_z;
    } box_in_t;

    typedef struct packed {
        logic                      box_valid;
        logic signed [COORD_W-1:0] out_min_x;
        logic signed [COORD_W-1:0] out_min_y;
        logic signed [COORD_W-1:0] out_min_z;
        logic signed [COORD_W-1:0] out_max_x;
        logic signed [COORD_W-1:0] out_max_y;
        logic signed [COORD_W-1:0] out_max_z;
    } box_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    // One row of the affine matrix plus its translation
    typedef struct packed {
        logic signed [COORD_W-1:0] c0;
        logic signed [COORD_W-1:0] c1;
        logic signed [COORD_W-1:0] c2;
        logic signed [COORD_W-1:0] t;
    } row_cfg_t;

    // Per-stage load enables for the datapath
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctl_t;

endpackage

// File: rtl/core/aat_row.sv
// ----------------------------------------------------------------------------
// aat_row
// One output axis: bounds of m_r0*x + m_r1*y + m_r2*z + t_r over the box.
// ----------------------------------------------------------------------------
// Each term depends on one coordinate only, and truncation and saturation are
// monotonic, so the extreme over all eight corners is the sum of the per-term
// extremes. Stage 1 multiplies, stage 2 sorts each term pair, stage 3 sums.
module aat_row (
    input  logic                                 clk,
    input  aat_pkg::pipe_ctl_t                   ctl,
    input  aat_pkg::row_cfg_t                    cfg,
    input  aat_pkg::vec_t                        lo,
    input  aat_pkg::vec_t                        hi,
    output logic signed [aat_pkg::COORD_W-1:0]   row_min,
    output logic signed [aat_pkg::COORD_W-1:0]   row_max
);

    localparam int PW = aat_pkg::PROD_W;
    localparam int TW = aat_pkg::TERM_W;
    localparam int SW = aat_pkg::SUM_W;
    localparam int CW = aat_pkg::COORD_W;

    logic signed [CW-1:0] coef  [3];
    logic signed [CW-1:0] lo_a  [3];
    logic signed [CW-1:0] hi_a  [3];

    logic signed [PW-1:0] prod_lo_reg [3];
    logic signed [PW-1:0] prod_hi_reg [3];
    logic signed [TW-1:0] tmin_reg    [3];
    logic signed [TW-1:0] tmax_reg    [3];
    logic signed [SW-1:0] sum_min_reg;
    logic signed [SW-1:0] sum_max_reg;
    logic signed [SW-1:0] sum_min_next;
    logic signed [SW-1:0] sum_max_next;

    assign coef[0] = cfg.c0;
    assign coef[1] = cfg.c1;
    assign coef[2] = cfg.c2;
    assign lo_a[0] = lo.x;
    assign lo_a[1] = lo.y;
    assign lo_a[2] = lo.z;
    assign hi_a[0] = hi.x;
    assign hi_a[1] = hi.y;
    assign hi_a[2] = hi.z;

    for (genvar j = 0; j < 3; j++) begin : g_term
        logic signed [TW-1:0] tl;
        logic signed [TW-1:0] th;

        // Drop the low fraction bits: floor of the product
        assign tl = prod_lo_reg[j][PW-1:aat_pkg::FRAC_W];
        assign th = prod_hi_reg[j][PW-1:aat_pkg::FRAC_W];

        always_ff @(posedge clk)
        begin
            if (ctl.en1)
            begin
                prod_lo_reg[j] <= PW'(coef[j]) * PW'(lo_a[j]);
                prod_hi_reg[j] <= PW'(coef[j]) * PW'(hi_a[j]);
            end
            if (ctl.en2)
            begin
                tmin_reg[j] <= (tl < th) ? tl : th;
                tmax_reg[j] <= (tl < th) ? th : tl;
            end
        end
    end

    always_comb
    begin
        sum_min_next = SW'(tmin_reg[0]) + SW'(tmin_reg[1]) + SW'(tmin_reg[2])
                     + SW'(cfg.t);
        sum_max_next = SW'(tmax_reg[0]) + SW'(tmax_reg[1]) + SW'(tmax_reg[2])
                     + SW'(cfg.t);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            sum_min_reg <= sum_min_next;
            sum_max_reg <= sum_max_next;
        end
    end

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic hi_ok;
        logic lo_ok;
        begin
            hi_ok = (v[SW-1:CW-1] == '0);
            lo_ok = (v[SW-1:CW-1] == '1);
            if (hi_ok || lo_ok)
                sat = v[CW-1:0];
            else if (v[SW-1])
                sat = {1'b1, {(CW-1){1'b0}}};
            else
                sat = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    assign row_min = sat(sum_min_reg);
    assign row_max = sat(sum_max_reg);

endmodule

// File: rtl/core/aabb_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit
// World-space bounding box of an object-space box under a 3x4 affine map.
// ----------------------------------------------------------------------------
// Usage:
//   src_valid/src_ready/src_box carry one request: a has-box flag and the
//   object-space min and max corners, Q16.16. dst_valid/dst_ready/dst_box
//   return the world box, each axis saturated to 32 bits; with no box the
//   result is flagged invalid and all coordinates are zero.
//   The six 64-bit matrix registers are written through cfg_we, cfg_index
//   and cfg_data, one per cycle; indexes above five are ignored. Write them
//   only while no request is in flight.
//   dst_valid rises after four register stages: multiply, term sort, sum,
//   saturate into the output register, the first loaded on the edge that
//   takes a request. Eighteen 32x32 multipliers work in parallel, so one
//   request is taken every cycle unless a dst_ready stall backs it up.
//   When dst_ready is low the pipeline holds; empty stages still fill, so up
//   to four requests queue before src_ready drops.
//   Reset clears all stage valid bits and loads the identity transform.
module aabb_affine_transform_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_ready,
    input  aat_pkg::box_in_t                    src_box,
    output logic                                dst_valid,
    input  logic                                dst_ready,
    output aat_pkg::box_out_t                   dst_box,
    input  logic                                cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aat_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = aat_pkg::COORD_W;
    localparam int DW = aat_pkg::CFG_DATA_W;

    logic [DW-1:0] m00_m01_reg;
    logic [DW-1:0] m02_tx_reg;
    logic [DW-1:0] m10_m11_reg;
    logic [DW-1:0] m12_ty_reg;
    logic [DW-1:0] m20_m21_reg;
    logic [DW-1:0] m22_tz_reg;

    logic v1_reg, v2_reg, v3_reg, dst_valid_reg;
    logic hb1_reg, hb2_reg, hb3_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    aat_pkg::pipe_ctl_t ctl;
    aat_pkg::box_out_t  dst_box_reg;
    aat_pkg::box_out_t  dst_box_next;
    aat_pkg::vec_t      lo, hi;
    aat_pkg::row_cfg_t  cfg_x, cfg_y, cfg_z;
    logic signed [CW-1:0] min_x, max_x, min_y, max_y, min_z, max_z;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m00_m01_reg <= aat_pkg::RST_M00_M01;
            m02_tx_reg  <= aat_pkg::RST_M02_TX;
            m10_m11_reg <= aat_pkg::RST_M10_M11;
            m12_ty_reg  <= aat_pkg::RST_M12_TY;
            m20_m21_reg <= aat_pkg::RST_M20_M21;
            m22_tz_reg  <= aat_pkg::RST_M22_TZ;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aat_pkg::REG_M00_M01: m00_m01_reg <= cfg_data;
                aat_pkg::REG_M02_TX:  m02_tx_reg  <= cfg_data;
                aat_pkg::REG_M10_M11: m10_m11_reg <= cfg_data;
                aat_pkg::REG_M12_TY:  m12_ty_reg  <= cfg_data;
                aat_pkg::REG_M20_M21: m20_m21_reg <= cfg_data;
                aat_pkg::REG_M22_TZ:  m22_tz_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_x = '{c0: m00_m01_reg[DW-1:CW], c1: m00_m01_reg[CW-1:0],
                     c2: m02_tx_reg[DW-1:CW],  t:  m02_tx_reg[CW-1:0]};
    assign cfg_y = '{c0: m10_m11_reg[DW-1:CW], c1: m10_m11_reg[CW-1:0],
                     c2: m12_ty_reg[DW-1:CW],  t:  m12_ty_reg[CW-1:0]};
    assign cfg_z = '{c0: m20_m21_reg[DW-1:CW], c1: m20_m21_reg[CW-1:0],
                     c2: m22_tz_reg[DW-1:CW],  t:  m22_tz_reg[CW-1:0]};

    // A stage loads when it is empty or its contents move on
    assign rdy4 = !dst_valid_reg || dst_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign src_ready = rdy1;

    assign ctl = '{en1: rdy1, en2: rdy2, en3: rdy3};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= src_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                dst_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            hb1_reg <= src_box.has_box;
        if (rdy2)
            hb2_reg <= hb1_reg;
        if (rdy3)
            hb3_reg <= hb2_reg;
        if (rdy4)
            dst_box_reg <= dst_box_next;
    end

    assign lo = '{x: src_box.in_min_x, y: src_box.in_min_y, z: src_box.in_min_z};
    assign hi = '{x: src_box.in_max_x, y: src_box.in_max_y, z: src_box.in_max_z};

    aat_row u_row_x (
        .clk     (clk),
        .ctl     (ctl),
        .cfg     (cfg_x),
        .lo      (lo),
        .hi      (hi),
        .row_min (min_x),
        .row_max (max_x)
    );

    aat_row u_row_y (
        .clk     (clk),
        .ctl     (ctl),
        .cfg     (cfg_y),
        .lo      (lo),
        .hi      (hi),
        .row_min (min_y),
        .row_max (max_y)
    );

    aat_row u_row_z (
        .clk     (clk),
        .ctl     (ctl),
        .cfg     (cfg_z),
        .lo      (lo),
        .hi      (hi),
        .row_min (min_z),
        .row_max (max_z)
    );

    // Zero the coordinates of a request without a box
    always_comb
    begin
        if (hb3_reg)
            dst_box_next = '{box_valid: 1'b1,
                             out_min_x: min_x, out_min_y: min_y, out_min_z: min_z,
                             out_max_x: max_x, out_max_y: max_y, out_max_z: max_z};
        else
            dst_box_next = '0;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_box   = dst_box_reg;

    a_empty_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_box.box_valid |->
            dst_box.out_min_x == 0 && dst_box.out_max_x == 0 &&
            dst_box.out_min_y == 0 && dst_box.out_max_y == 0 &&
            dst_box.out_min_z == 0 && dst_box.out_max_z == 0)
        else $error("empty box result has non-zero coordinates");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_box.box_valid |->
            dst_box.out_min_x <= dst_box.out_max_x &&
            dst_box.out_min_y <= dst_box.out_max_y &&
            dst_box.out_min_z <= dst_box.out_max_z)
        else $error("world box minimum above maximum");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> src_ready)
        else $error("first stage empty but request refused");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(hb1_reg))
        else $error("stalled first stage lost or changed its request");

endmodule

// File: tb/aabb_world_box_checker.sv
// ----------------------------------------------------------------------------
// aabb_world_box_checker
// Watches the request, result and register ports of the box transform unit,
// keeps its own copy of the matrix, predicts the world box for every request
// taken and compares each returned box, field by field, in order.
// ----------------------------------------------------------------------------
module aabb_world_box_checker
    import aat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    input  logic                  src_ready,
    input  box_in_t               src_box,
    input  logic                  dst_valid,
    input  logic                  dst_ready,
    input  box_out_t              dst_box,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam int                        REPORT_MAX = 10;

    logic [CFG_DATA_W-1:0] matrix_regs [6];
    box_out_t              pending_boxes [$];
    box_out_t              want;
    int                    mismatches;
    logic                  took;
    logic                  gave;

    // Q16.16 product, low fraction bits dropped (rounds toward minus infinity)
    function automatic longint q_product(input logic signed [COORD_W-1:0] a,
                                         input logic signed [COORD_W-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> FRAC_W;
    endfunction

    function automatic logic signed [COORD_W-1:0] row_coord(
        input int r,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic signed [COORD_W-1:0] pz);
        logic [CFG_DATA_W-1:0]     lin;
        logic [CFG_DATA_W-1:0]     aff;
        logic signed [COORD_W-1:0] t_off;
        longint                    acc;
        lin   = matrix_regs[2*r];
        aff   = matrix_regs[2*r+1];
        t_off = aff[COORD_W-1:0];
        acc   = q_product(lin[CFG_DATA_W-1:COORD_W], px)
              + q_product(lin[COORD_W-1:0], py)
              + q_product(aff[CFG_DATA_W-1:COORD_W], pz)
              + longint'(t_off);
        if (acc > longint'(COORD_MAX))
            return COORD_MAX;
        if (acc < longint'(COORD_MIN))
            return COORD_MIN;
        return acc[COORD_W-1:0];
    endfunction

    function automatic box_out_t world_box(input box_in_t b);
        box_out_t                  res;
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [COORD_W-1:0] mn [3];
        logic signed [COORD_W-1:0] mx [3];
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] w;
        res = '0;
        if (!b.has_box)
            return res;
        lo[0] = b.in_min_x;
        lo[1] = b.in_min_y;
        lo[2] = b.in_min_z;
        hi[0] = b.in_max_x;
        hi[1] = b.in_max_y;
        hi[2] = b.in_max_z;
        // corners built as given, an inverted box is not reordered
        for (int c = 0; c < 8; c++)
        begin
            px = c[2] ? hi[0] : lo[0];
            py = c[1] ? hi[1] : lo[1];
            pz = c[0] ? hi[2] : lo[2];
            for (int r = 0; r < 3; r++)
            begin
                w = row_coord(r, px, py, pz);
                if (c == 0 || w < mn[r])
                    mn[r] = w;
                if (c == 0 || w > mx[r])
                    mx[r] = w;
            end
        end
        res.box_valid = 1'b1;
        res.out_min_x = mn[0];
        res.out_min_y = mn[1];
        res.out_min_z = mn[2];
        res.out_max_x = mx[0];
        res.out_max_y = mx[1];
        res.out_max_z = mx[2];
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input logic signed [COORD_W-1:0] exp_v,
                                 input logic signed [COORD_W-1:0] got_v);
        mismatches++;
        fail_count++;
        if (mismatches <= REPORT_MAX)
            $display("%t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                     $realtime, field, exp_v, exp_v, got_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_regs[REG_M00_M01] <= RST_M00_M01;
            matrix_regs[REG_M02_TX]  <= RST_M02_TX;
            matrix_regs[REG_M10_M11] <= RST_M10_M11;
            matrix_regs[REG_M12_TY]  <= RST_M12_TY;
            matrix_regs[REG_M20_M21] <= RST_M20_M21;
            matrix_regs[REG_M22_TZ]  <= RST_M22_TZ;
            pending_boxes.delete();
            outstanding <= 0;
            fail_count  = 0;
            checked     = 0;
            mismatches  = 0;
        end
        else
        begin
            took = src_valid && src_ready;
            gave = 1'b0;
            if (took)
                pending_boxes.push_back(world_box(src_box));
            if (dst_valid && dst_ready)
            begin
                if (pending_boxes.size() == 0)
                begin
                    mismatches++;
                    fail_count++;
                    if (mismatches <= REPORT_MAX)
                        $display("%t: result returned with no request outstanding",
                                 $realtime);
                end
                else
                begin
                    gave = 1'b1;
                    want = pending_boxes.pop_front();
                    checked++;
                    if (dst_box.box_valid !== want.box_valid)
                        flag_mismatch("box_valid", COORD_W'(want.box_valid),
                                      COORD_W'(dst_box.box_valid));
                    if (dst_box.out_min_x !== want.out_min_x)
                        flag_mismatch("out_min_x", want.out_min_x, dst_box.out_min_x);
                    if (dst_box.out_min_y !== want.out_min_y)
                        flag_mismatch("out_min_y", want.out_min_y, dst_box.out_min_y);
                    if (dst_box.out_min_z !== want.out_min_z)
                        flag_mismatch("out_min_z", want.out_min_z, dst_box.out_min_z);
                    if (dst_box.out_max_x !== want.out_max_x)
                        flag_mismatch("out_max_x", want.out_max_x, dst_box.out_max_x);
                    if (dst_box.out_max_y !== want.out_max_y)
                        flag_mismatch("out_max_y", want.out_max_y, dst_box.out_max_y);
                    if (dst_box.out_max_z !== want.out_max_z)
                        flag_mismatch("out_max_z", want.out_max_z, dst_box.out_max_z);
                end
            end
            outstanding <= outstanding + int'(took) - int'(gave);
            // writes above the last register are dropped
            if (cfg_we && cfg_index <= REG_M22_TZ)
                matrix_regs[cfg_index] <= cfg_data;
        end
    end

endmodule

// File: tb/aabb_affine_transform_unit_test.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit_test
// Drives boxes and matrix settings into the box transform unit: a directed
// set of corner cases under the identity, saturating and mixed-sign matrices,
// then random boxes under random matrices with varying source and sink
// stalls, including one long sink hold-off. A checker predicts every result.
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aat_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    localparam logic [COORD_W-1:0] Q_ZERO     = 32'h0000_0000;
    localparam logic [COORD_W-1:0] Q_ONE      = 32'h0001_0000;
    localparam logic [COORD_W-1:0] Q_NEG_ONE  = 32'hFFFF_0000;
    localparam logic [COORD_W-1:0] Q_HALF     = 32'h0000_8000;
    localparam logic [COORD_W-1:0] Q_NEG_HALF = 32'hFFFF_8000;
    localparam logic [COORD_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MIN      = 32'h8000_0000;
    localparam logic [COORD_W-1:0] Q_NEG_LSB  = 32'hFFFF_FFFF;

    localparam int HOLD_CYCLES    = 300;
    localparam int BOXES_PER_LOAD = 125;
    localparam int PHASES         = 5;
    localparam int SEND_IDLE_TAB [PHASES] = '{0, 65, 0, 30, -1};
    localparam int RECV_STALL_TAB[PHASES] = '{0, 0, 65, 30, -1};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  src_valid = 1'b0;
    logic                  src_ready;
    box_in_t               src_box = '0;
    logic                  dst_valid;
    logic                  dst_ready = 1'b0;
    box_out_t              dst_box;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int checked;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int boxes_sent = 0;
    int matrix_loads = 0;
    int hold_left = 0;
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;

    aabb_affine_transform_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_box   (src_box),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_box   (dst_box),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aabb_world_box_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_box     (src_box),
        .dst_valid   (dst_valid),
        .dst_ready   (dst_ready),
        .dst_box     (dst_box),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink: random stalls, plus a long hold-off whenever the toggle flips
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            dst_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            dst_ready <= 1'b0;
        end
        else
            dst_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

    function automatic box_in_t mk_box(input logic has, input logic [COORD_W-1:0] a,
                                       input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] c,
                                       input logic [COORD_W-1:0] d, input logic [COORD_W-1:0] e,
                                       input logic [COORD_W-1:0] f);
        box_in_t bx;
        bx.has_box  = has;
        bx.in_min_x = a;
        bx.in_min_y = b;
        bx.in_min_z = c;
        bx.in_max_x = d;
        bx.in_max_y = e;
        bx.in_max_z = f;
        return bx;
    endfunction

    // mix of full-range, modest and extreme Q16.16 values
    function automatic logic [COORD_W-1:0] rand_q(input int modest_bits);
        int pick;
        pick = $urandom_range(19);
        if (pick < 8)
            return $urandom;
        if (pick < 17)
            return $urandom_range(0, (1 << modest_bits) - 1) - (1 << (modest_bits - 1));
        case ($urandom_range(4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return Q_NEG_LSB;
            3:       return Q_ONE;
            default: return Q_ZERO;
        endcase
    endfunction

    function automatic box_in_t random_box();
        box_in_t                bx;
        logic [COORD_W-1:0]     a;
        logic [COORD_W-1:0]     b;
        logic [COORD_W-1:0]     c;
        logic [COORD_W-1:0]     d;
        logic [COORD_W-1:0]     e;
        logic [COORD_W-1:0]     f;
        a = rand_q(22);
        b = rand_q(22);
        c = rand_q(22);
        d = rand_q(22);
        e = rand_q(22);
        f = rand_q(22);
        bx = mk_box($urandom_range(9) != 0, a, b, c, d, e, f);
        // mostly well-ordered boxes, the rest left as drawn
        if ($urandom_range(3) != 0)
        begin
            if ($signed(bx.in_min_x) > $signed(bx.in_max_x))
                {bx.in_min_x, bx.in_max_x} = {bx.in_max_x, bx.in_min_x};
            if ($signed(bx.in_min_y) > $signed(bx.in_max_y))
                {bx.in_min_y, bx.in_max_y} = {bx.in_max_y, bx.in_min_y};
            if ($signed(bx.in_min_z) > $signed(bx.in_max_z))
                {bx.in_min_z, bx.in_max_z} = {bx.in_max_z, bx.in_min_z};
        end
        return bx;
    endfunction

    task automatic send_box(input box_in_t bx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_box   <= bx;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        boxes_sent++;
    endtask

    // drop valid and hold until every request has come back
    task automatic wait_idle();
        src_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_matrix(input logic [CFG_DATA_W-1:0] r0, input logic [CFG_DATA_W-1:0] r1,
                                  input logic [CFG_DATA_W-1:0] r2, input logic [CFG_DATA_W-1:0] r3,
                                  input logic [CFG_DATA_W-1:0] r4, input logic [CFG_DATA_W-1:0] r5);
        write_reg(REG_M00_M01, r0);
        write_reg(REG_M02_TX,  r1);
        write_reg(REG_M10_M11, r2);
        write_reg(REG_M12_TY,  r3);
        write_reg(REG_M20_M21, r4);
        write_reg(REG_M22_TZ,  r5);
        // junk to the unused indexes must leave the matrix alone
        write_reg(REG_NONE_LO, {$urandom, $urandom});
        write_reg(REG_NONE_HI, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge clk);
        matrix_loads++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_pair();
        return {rand_q(20), rand_q(20)};
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity from reset
        send_box(mk_box(1'b0, Q_MAX, Q_MIN, Q_ONE, Q_MIN, Q_MAX, 32'hDEAD_BEEF));
        send_box(mk_box(1'b1, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_box(mk_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(mk_box(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_box(mk_box(1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
        wait_idle();

        // largest positive terms everywhere: saturate both high and low
        program_matrix({Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX},
                       {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX});
        send_box(mk_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(mk_box(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_box(mk_box(1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
        send_box(mk_box(1'b1, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE,
                        Q_NEG_ONE));
        wait_idle();

        // most negative terms: saturate both ways
        program_matrix({Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN},
                       {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN});
        send_box(mk_box(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(mk_box(1'b1, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_box(mk_box(1'b0, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB,
                        Q_NEG_LSB));
        wait_idle();

        // mixed signs and halves: truncation of odd products toward minus infinity
        program_matrix({Q_NEG_HALF, Q_ONE}, {Q_HALF, 32'h0003_4000},
                       {Q_NEG_ONE, Q_ZERO}, {Q_ZERO, Q_MIN},
                       {Q_ZERO, Q_ZERO}, {Q_NEG_ONE, Q_MAX});
        send_box(mk_box(1'b1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                        32'h0000_0003, 32'h0000_0005, 32'h0000_0007));
        send_box(mk_box(1'b1, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_ZERO, Q_ZERO, Q_ZERO));
        send_box(mk_box(1'b1, 32'hFFFF_FFFD, 32'h0000_0002, 32'hFFFF_FFF9,
                        32'hFFFF_FFFB, 32'h0000_0009, 32'h0000_0001));
        send_box(mk_box(1'b1, Q_MIN, Q_NEG_ONE, Q_ZERO, Q_MAX, Q_ONE, Q_ONE));
        send_box(mk_box(1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int blk = 0; blk < 2; blk++)
            begin
                wait_idle();
                if (SEND_IDLE_TAB[ph] < 0)
                begin
                    send_idle_pct  = $urandom_range(80);
                    recv_stall_pct = $urandom_range(80);
                end
                else
                begin
                    send_idle_pct  = SEND_IDLE_TAB[ph];
                    recv_stall_pct = RECV_STALL_TAB[ph];
                end
                program_matrix(rand_pair(), rand_pair(), rand_pair(),
                               rand_pair(), rand_pair(), rand_pair());
                for (int i = 0; i < BOXES_PER_LOAD; i++)
                begin
                    // hold the sink off while requests keep coming, to fill the pipe
                    if (ph == 0 && blk == 0 && i == 20)
                        hold_toggle = ~hold_toggle;
                    send_box(random_box());
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Sent %0d boxes under %0d matrix settings, %0d world boxes compared.",
                 boxes_sent, matrix_loads + 1, checked);
        $display("Stall mixes: none, source only, sink only, both, random; one long sink hold.");
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
